### sv/scanline_polygon_fill_top_defines.svh
// Assertion macros for the scanline fill block
`ifndef SCANLINE_POLYGON_FILL_TOP_DEFINES_SVH
`define SCANLINE_POLYGON_FILL_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define SPF_ASSERT(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (prop)) else $error(msg);
`define SPF_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SPF_ASSERT(label, clk_sig, rst_sig, prop, msg)
`define SPF_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg)
`endif
`endif

### sv/spf_pkg.sv
package spf_pkg;

    localparam int MaxVertices  = 64;
    localparam int MaxCrossings = 16;

    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_FILL   = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [9:0] vertex_x;
        logic [9:0] vertex_y;
        logic [9:0] scan_row;
    } in_beat_t;

    typedef struct packed {
        logic [9:0]  span_row;
        logic [13:0] span_start;
        logic [13:0] span_end;
        logic        span_valid;
        logic        overflow;
        logic        last;
    } out_beat_t;

    // Command passed from the front part to the back part
    typedef struct packed {
        logic       is_fill;
        logic       is_append;
        logic [9:0] vertex_x;
        logic [9:0] vertex_y;
        logic [9:0] scan_row;
    } cmd_t;

endpackage

### sv/scanline_polygon_fill_top.sv
// Even-odd scanline polygon fill.
// Input channel (in_data/in_valid/in_stall) takes one beat per command:
// clear polygon, append vertex, or fill one row. Unused kinds are dropped.
// Output channel (out_data/out_valid/out_stall) gives one beat per fill span,
// sorted left to right, with last set on the row's final beat; a row with no
// span gives one beat with span_valid low.
// A front queue of two commands decouples input from the back part.
// A fill reads each edge through S_RD, S_RD2 and S_EDGE, runs a serial divide
// for each edge that spans the row, then an insertion sort of the crossings,
// then gives one span beat per pair of sorted crossings.
// The divider, one quotient bit per cycle, sets most of a fill's time.
// Reset clears the vertex count, queue and output register; vertex data
// itself is not cleared. When the receiver stalls, the current output beat
// holds and the back part waits before its next beat or command; the front
// queue keeps taking commands until it fills.
module scanline_polygon_fill_top #(
    parameter int MAX_VERTICES  = spf_pkg::MaxVertices,
    parameter int MAX_CROSSINGS = spf_pkg::MaxCrossings
) (
    input  logic               clk,
    input  logic               rst_n,
    input  spf_pkg::in_beat_t  in_data,
    input  logic               in_valid,
    output logic               in_stall,
    output spf_pkg::out_beat_t out_data,
    output logic               out_valid,
    input  logic               out_stall
);
    spf_pkg::cmd_t cmd;
    logic          cmd_valid, cmd_take;

    spf_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_data(in_data), .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take)
    );

    spf_back #(
        .MAX_VERTICES(MAX_VERTICES), .MAX_CROSSINGS(MAX_CROSSINGS)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
        .out_data(out_data), .out_valid(out_valid), .out_stall(out_stall)
    );
endmodule

### sv/spf_front.sv
// Front part: decodes beats, drops unused kinds, queues commands.
module spf_front (
    input  logic               clk,
    input  logic               rst_n,
    input  spf_pkg::in_beat_t  in_data,
    input  logic               in_valid,
    output logic               in_stall,
    output spf_pkg::cmd_t      cmd,
    output logic               cmd_valid,
    input  logic               cmd_take
);
    localparam int Depth = 2;

    spf_pkg::cmd_t q_reg [Depth];
    logic [0:0] wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;
    logic       is_clear;
    spf_pkg::cmd_t dec;

    // Classify the incoming beat
    always_comb
    begin
        dec.is_fill   = (in_data.kind == spf_pkg::KIND_FILL);
        dec.is_append = (in_data.kind == spf_pkg::KIND_APPEND);
        dec.vertex_x  = in_data.vertex_x;
        dec.vertex_y  = in_data.vertex_y;
        dec.scan_row  = in_data.scan_row;
    end

    assign is_clear  = (in_data.kind == spf_pkg::KIND_CLEAR);
    assign in_stall  = (cnt_reg == 2'(Depth));
    assign push      = in_valid && !in_stall && (dec.is_fill || dec.is_append || is_clear);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign pop       = cmd_valid && cmd_take;

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

### sv/spf_back.sv
`include "scanline_polygon_fill_top_defines.svh"
// Back part: vertex store, edge walk with serial divide, insertion sort, span output.
module spf_back #(
    parameter int MAX_VERTICES  = spf_pkg::MaxVertices,
    parameter int MAX_CROSSINGS = spf_pkg::MaxCrossings
) (
    input  logic               clk,
    input  logic               rst_n,
    input  spf_pkg::cmd_t      cmd,
    input  logic               cmd_valid,
    output logic               cmd_take,
    output spf_pkg::out_beat_t out_data,
    output logic               out_valid,
    input  logic               out_stall
);
    localparam int VW = $clog2(MAX_VERTICES + 1);
    localparam int VI = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_CROSSINGS + 1);
    localparam int CI = $clog2(MAX_CROSSINGS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_EDGE  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_SORT  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;
    localparam logic [2:0] S_RD2   = 3'd6;

    logic [9:0] vx_mem [MAX_VERTICES];
    logic [9:0] vy_mem [MAX_VERTICES];
    logic [13:0] cr_reg [MAX_CROSSINGS];

    logic [2:0]    state_reg;
    logic [VW-1:0] vcount_reg;
    logic [VW-1:0] edge_reg;
    logic [CW-1:0] ccount_reg;
    logic          ovf_reg;
    logic [9:0]    row_reg;
    logic [9:0]    ax_reg, ay_reg;
    logic [9:0]    rdx_reg, rdy_reg;
    logic [VI-1:0] rd_addr;
    // divider
    logic [23:0]   dnum_reg;
    logic [23:0]   dquo_reg;
    logic [24:0]   drem_reg;
    logic [9:0]    dden_reg;
    logic          dneg_reg;
    logic [4:0]    dstep_reg;
    logic [9:0]    x1_reg;
    // sort
    logic [CW-1:0] si_reg, sj_reg;
    logic [13:0]   sv_reg;
    logic          s_ins_reg;
    logic [CW-1:0] pair_reg;

    logic [CW-1:0] pairs;
    logic          out_free;
    logic [CI-1:0] lo_idx, hi_idx;

    assign pairs    = ccount_reg >> 1;
    assign out_free = !out_valid || !out_stall;
    assign cmd_take = (state_reg == S_IDLE) && cmd_valid && out_free;
    assign lo_idx   = CI'({pair_reg, 1'b0});
    assign hi_idx   = CI'({pair_reg, 1'b1});

    // Vertex store with registered read
    always_ff @(posedge clk)
    begin
        if (cmd_take && cmd.is_append && vcount_reg < VW'(MAX_VERTICES))
        begin
            vx_mem[vcount_reg[VI-1:0]] <= cmd.vertex_x;
            vy_mem[vcount_reg[VI-1:0]] <= cmd.vertex_y;
        end
        rdx_reg <= vx_mem[rd_addr];
        rdy_reg <= vy_mem[rd_addr];
    end

    // Read address: vertex i in S_RD, its successor otherwise
    logic [VW-1:0] nxt;
    assign nxt = (edge_reg + 1'b1 < vcount_reg) ? edge_reg + 1'b1 : '0;
    assign rd_addr = (state_reg == S_RD) ? edge_reg[VI-1:0] : nxt[VI-1:0];

    // Edge orientation and span test; the far end is still on the read port
    logic [9:0] x1, y1, x2, y2;
    logic       hit;
    always_comb
    begin
        if (rdy_reg < ay_reg)
        begin
            x1 = rdx_reg; y1 = rdy_reg; x2 = ax_reg; y2 = ay_reg;
        end
        else
        begin
            x1 = ax_reg; y1 = ay_reg; x2 = rdx_reg; y2 = rdy_reg;
        end
        hit = (row_reg > y1) && (row_reg < y2);
    end

    logic [10:0] dxa;
    logic        dxn;
    logic [23:0] prod;
    assign dxn  = x2 < x1;
    assign dxa  = dxn ? 11'(x1 - x2) : 11'(x2 - x1);
    assign prod = 24'(row_reg - y1) * 24'({dxa, 4'b0});

    // Restoring divide step
    logic [24:0] rtry;
    assign rtry = {drem_reg[23:0], dnum_reg[23]};

    // Full quotient at the last step, with the bit decided this cycle
    logic [23:0] q_fin;
    assign q_fin = {dquo_reg[22:0], (rtry >= 25'(dden_reg))};

    logic [14:0] cx_full;
    assign cx_full = dneg_reg ? 15'({x1_reg, 4'b0}) - 15'(q_fin)
                              : 15'({x1_reg, 4'b0}) + 15'(q_fin);

    logic sort_done;
    assign sort_done = (si_reg >= ccount_reg);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RD2)
        begin
            ax_reg <= rdx_reg;
            ay_reg <= rdy_reg;
        end
        if (state_reg == S_EDGE && hit)
        begin
            dnum_reg <= prod;
            dden_reg <= y2 - y1;
            dneg_reg <= dxn;
            x1_reg   <= x1;
            drem_reg <= '0;
            dquo_reg <= '0;
        end
        else if (state_reg == S_DIV)
        begin
            dnum_reg <= dnum_reg << 1;
            if (rtry >= 25'(dden_reg))
            begin
                drem_reg <= rtry - 25'(dden_reg);
                dquo_reg <= {dquo_reg[22:0], 1'b1};
            end
            else
            begin
                drem_reg <= rtry;
                dquo_reg <= {dquo_reg[22:0], 1'b0};
            end
        end
        if (cmd_take)
        begin
            row_reg <= cmd.scan_row;
        end
        // crossing store and insertion sort (one shift per cycle)
        if (state_reg == S_DIV && dstep_reg == 5'd23 && ccount_reg < CW'(MAX_CROSSINGS))
        begin
            cr_reg[ccount_reg[CI-1:0]] <= 14'(cx_full);
        end
        if (state_reg == S_SORT && !sort_done)
        begin
            if (!s_ins_reg)
            begin
                sv_reg <= cr_reg[si_reg[CI-1:0]];
            end
            else if (sj_reg != '0 && cr_reg[sj_reg[CI-1:0] - 1'b1] > sv_reg)
            begin
                cr_reg[sj_reg[CI-1:0]] <= cr_reg[sj_reg[CI-1:0] - 1'b1];
            end
            else
            begin
                cr_reg[sj_reg[CI-1:0]] <= sv_reg;
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            vcount_reg <= '0;
            edge_reg   <= '0;
            ccount_reg <= '0;
            ovf_reg    <= 1'b0;
            dstep_reg  <= '0;
            si_reg     <= '0;
            sj_reg     <= '0;
            s_ins_reg  <= 1'b0;
            pair_reg   <= '0;
            out_valid  <= 1'b0;
            out_data   <= '0;
        end
        else
        begin
            if (out_valid && !out_stall && state_reg != S_EMIT)
            begin
                out_valid <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_take)
                    begin
                        if (cmd.is_fill)
                        begin
                            edge_reg   <= '0;
                            ccount_reg <= '0;
                            ovf_reg    <= 1'b0;
                            state_reg  <= (vcount_reg == '0) ? S_SORT : S_RD;
                            si_reg     <= CW'(1);
                            s_ins_reg  <= 1'b0;
                        end
                        else if (cmd.is_append)
                        begin
                            if (vcount_reg < VW'(MAX_VERTICES))
                            begin
                                vcount_reg <= vcount_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            vcount_reg <= '0;
                        end
                    end
                end
                S_RD:
                begin
                    state_reg <= S_RD2;
                end
                S_RD2:
                begin
                    state_reg <= S_EDGE;
                end
                S_EDGE:
                begin
                    if (hit)
                    begin
                        dstep_reg <= '0;
                        state_reg <= S_DIV;
                    end
                    else if (edge_reg + 1'b1 >= vcount_reg)
                    begin
                        state_reg <= S_SORT;
                    end
                    else
                    begin
                        edge_reg  <= edge_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_DIV:
                begin
                    dstep_reg <= dstep_reg + 1'b1;
                    if (dstep_reg == 5'd23)
                    begin
                        if (ccount_reg < CW'(MAX_CROSSINGS))
                        begin
                            ccount_reg <= ccount_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (edge_reg + 1'b1 >= vcount_reg)
                        begin
                            state_reg <= S_SORT;
                        end
                        else
                        begin
                            edge_reg  <= edge_reg + 1'b1;
                            state_reg <= S_RD;
                        end
                    end
                end
                S_SORT:
                begin
                    if (sort_done)
                    begin
                        pair_reg  <= '0;
                        state_reg <= S_EMIT;
                    end
                    else if (!s_ins_reg)
                    begin
                        s_ins_reg <= 1'b1;
                        sj_reg    <= si_reg;
                    end
                    else if (sj_reg != '0 && cr_reg[sj_reg[CI-1:0] - 1'b1] > sv_reg)
                    begin
                        sj_reg <= sj_reg - 1'b1;
                    end
                    else
                    begin
                        s_ins_reg <= 1'b0;
                        si_reg    <= si_reg + 1'b1;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid           <= 1'b1;
                        out_data.span_row   <= row_reg;
                        out_data.overflow   <= ovf_reg;
                        if (pairs == '0)
                        begin
                            out_data.span_start <= '0;
                            out_data.span_end   <= '0;
                            out_data.span_valid <= 1'b0;
                            out_data.last       <= 1'b1;
                            state_reg           <= S_IDLE;
                        end
                        else
                        begin
                            out_data.span_start <= cr_reg[lo_idx];
                            out_data.span_end   <= cr_reg[hi_idx];
                            out_data.span_valid <= 1'b1;
                            out_data.last       <= (pair_reg + 1'b1 == pairs);
                            pair_reg            <= pair_reg + 1'b1;
                            if (pair_reg + 1'b1 == pairs)
                            begin
                                state_reg <= S_IDLE;
                            end
                        end
                    end
                    else if (out_valid && !out_stall)
                    begin
                        out_valid <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `SPF_ASSERT(a_ccount_cap, clk, rst_n,
        ccount_reg <= CW'(MAX_CROSSINGS), "crossing count over capacity")
    `SPF_ASSERT(a_vcount_cap, clk, rst_n,
        vcount_reg <= VW'(MAX_VERTICES), "vertex count over capacity")
    `SPF_ASSERT(a_take_idle, clk, rst_n,
        !cmd_take || state_reg == S_IDLE, "command taken while busy")
    `SPF_ASSERT_NEXT(a_div_len, clk, rst_n,
        state_reg == S_DIV && dstep_reg != 5'd23, state_reg == S_DIV, "divide cut short")
endmodule
